[src/idq_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// idq_pkg
// Shared types, codes and tables of the intra block dequantizer.
// ---------------------------------------------------------------------------
package idq_pkg;

  localparam logic [1:0] KIND_COEFF = 2'd0;
  localparam logic [1:0] KIND_LOAD  = 2'd1;
  localparam logic [1:0] KIND_SLICE = 2'd2;

  localparam logic [1:0] COMP_LUMA = 2'd0;
  localparam logic [1:0] COMP_CB   = 2'd1;
  localparam logic [1:0] COMP_CR   = 2'd2;

  localparam logic [2:0] BLOCK_CB = 3'd4;

  localparam logic signed [15:0] PRED_RESET = 16'sd1024;
  localparam logic signed [15:0] AC_MAX     = 16'sd2047;
  localparam logic signed [15:0] AC_MIN     = -16'sd2048;
  localparam logic signed [14:0] ADDR_RESET = -15'sd2;

  localparam logic [5:0] LAST_INDEX = 6'd63;

  // zigzag index of each raster position
  localparam logic [5:0] ZZ_OF_RASTER [64] = '{
     6'd0,  6'd1,  6'd5,  6'd6, 6'd14, 6'd15, 6'd27, 6'd28,
     6'd2,  6'd4,  6'd7, 6'd13, 6'd16, 6'd26, 6'd29, 6'd42,
     6'd3,  6'd8, 6'd12, 6'd17, 6'd25, 6'd30, 6'd41, 6'd43,
     6'd9, 6'd11, 6'd18, 6'd24, 6'd31, 6'd40, 6'd44, 6'd53,
    6'd10, 6'd19, 6'd23, 6'd32, 6'd39, 6'd45, 6'd52, 6'd54,
    6'd20, 6'd22, 6'd33, 6'd38, 6'd46, 6'd51, 6'd55, 6'd60,
    6'd21, 6'd34, 6'd37, 6'd47, 6'd50, 6'd56, 6'd59, 6'd61,
    6'd35, 6'd36, 6'd48, 6'd49, 6'd57, 6'd58, 6'd62, 6'd63
  };

  typedef struct packed {
    logic       in_ready;
    logic       accept;
    logic       issue;
    logic [5:0] index;
    logic       clear_store;
  } cmd_t;

  typedef struct packed {
    logic advance;
  } status_t;

endpackage
`default_nettype wire

[src/idq_if.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// idq_if
// Valid/ready channels: coefficient, load and slice items in, recon items out.
// ---------------------------------------------------------------------------
interface idq_coeff_if;
  logic              valid;
  logic              ready;
  logic [1:0]        kind;
  logic [2:0]        block_number;
  logic [12:0]       mb_address;
  logic [4:0]        quant_scale;
  logic [5:0]        position;
  logic signed [8:0] level;
  logic [7:0]        matrix_value;
  logic              last_coeff;

  modport source (
    output valid, kind, block_number, mb_address, quant_scale, position, level,
      matrix_value, last_coeff,
    input  ready
  );
  modport sink (
    input  valid, kind, block_number, mb_address, quant_scale, position, level,
      matrix_value, last_coeff,
    output ready
  );
endinterface

interface idq_recon_if;
  logic               valid;
  logic               ready;
  logic [2:0]         row;
  logic [2:0]         column;
  logic signed [15:0] recon_value;
  logic               last_out;

  modport source (output valid, row, column, recon_value, last_out, input ready);
  modport sink (input valid, row, column, recon_value, last_out, output ready);
endinterface
`default_nettype wire

[src/idq_ctrl.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// idq_ctrl
// Sequencer: takes items while idle, then issues the 64 raster reads.
// ---------------------------------------------------------------------------
module idq_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  wire logic [1:0]      in_kind,
  input  wire logic            in_last_coeff,
  input  wire idq_pkg::status_t status,
  output idq_pkg::cmd_t        cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EMIT = 1'b1;

  logic       state;
  logic       state_next;
  logic [5:0] index;
  logic [5:0] index_next;
  logic       accept;
  logic       starts_block;
  logic       last_issue;

  assign accept       = in_valid && (state == S_IDLE);
  assign starts_block = accept && (in_kind == idq_pkg::KIND_COEFF) && in_last_coeff;
  assign last_issue   = (state == S_EMIT) && status.advance && (index == idq_pkg::LAST_INDEX);

  always_comb begin
    state_next = state;
    index_next = index;
    case (state)
      S_IDLE: begin
        if (starts_block) begin
          state_next = S_EMIT;
          index_next = '0;
        end
      end
      S_EMIT: begin
        if (status.advance) begin
          index_next = index + 6'd1;
          if (index == idq_pkg::LAST_INDEX) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      index <= '0;
    end else begin
      state <= state_next;
      index <= index_next;
    end
  end

  always_comb begin
    cmd.in_ready    = (state == S_IDLE);
    cmd.accept      = accept;
    cmd.issue       = (state == S_EMIT);
    cmd.index       = index;
    cmd.clear_store = last_issue;
  end

endmodule
`default_nettype wire

[src/idq_datapath.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// idq_datapath
// Stores, predictors and the four-stage dequantize pipeline.
// ---------------------------------------------------------------------------
module idq_datapath #(
  parameter int MB_ADDRESS_MAX = 8191
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire idq_pkg::cmd_t     cmd,
  input  wire logic [1:0]        kind,
  input  wire logic [2:0]        block_number,
  input  wire logic [12:0]       mb_address,
  input  wire logic [4:0]        quant_scale,
  input  wire logic [5:0]        position,
  input  wire logic signed [8:0] level,
  input  wire logic [7:0]        matrix_value,
  input  wire logic              last_coeff,
  output idq_pkg::status_t       status,
  idq_recon_if.source            recon_ch
);

  localparam logic [31:0] ADDR_LIMIT = 32'(MB_ADDRESS_MAX);

  // memories
  logic signed [8:0] coeff_mem [64];
  logic [7:0]        matrix_mem [64];
  logic [63:0]       coeff_written;

  // predictors and block context
  logic signed [15:0] luma_pred;
  logic signed [15:0] cb_pred;
  logic signed [15:0] cr_pred;
  logic signed [14:0] last_addr;
  logic signed [15:0] dc_base;
  logic [1:0]         dc_comp;
  logic [4:0]         blk_scale;

  logic               advance;
  logic               coeff_accept;
  logic               block_start;
  logic [12:0]        addr_sat;
  logic signed [15:0] addr_diff;
  logic               skip;
  logic [1:0]         comp_sel;
  logic signed [15:0] base_sel;

  // pipeline registers
  logic               a_valid;
  logic [5:0]         a_k;
  logic signed [8:0]  a_level;
  logic               a_written;
  logic [7:0]         a_mval;
  logic [4:0]         a_scale;
  logic               b_valid;
  logic [5:0]         b_k;
  logic signed [8:0]  b_level;
  logic signed [14:0] b_prod;
  logic [7:0]         b_mval;
  logic               c_valid;
  logic [5:0]         c_k;
  logic signed [8:0]  c_level;
  logic signed [22:0] c_prod;

  logic signed [8:0]  a_level_eff;
  logic signed [5:0]  scale_s;
  logic signed [22:0] quot;
  logic signed [22:0] odd_val;
  logic signed [15:0] ac_val;
  logic signed [16:0] dc_sum;
  logic signed [15:0] dc_val;

  logic               out_valid;
  logic [5:0]         out_k;
  logic signed [15:0] out_value;

  assign advance        = !out_valid || recon_ch.ready;
  assign status.advance = advance;
  assign coeff_accept   = cmd.accept && (kind == idq_pkg::KIND_COEFF);
  assign block_start    = coeff_accept && last_coeff;

  // skip detection and predictor choice for the new block
  always_comb begin
    addr_sat = mb_address;
    if ({19'd0, mb_address} > ADDR_LIMIT) begin
      addr_sat = ADDR_LIMIT[12:0];
    end
    addr_diff = $signed({3'd0, addr_sat}) - 16'(last_addr);
    skip      = addr_diff > 16'sd1;
    if (block_number < idq_pkg::BLOCK_CB) begin
      comp_sel = idq_pkg::COMP_LUMA;
      base_sel = (skip && (block_number == 3'd0)) ? idq_pkg::PRED_RESET : luma_pred;
    end else if (block_number == idq_pkg::BLOCK_CB) begin
      comp_sel = idq_pkg::COMP_CB;
      base_sel = skip ? idq_pkg::PRED_RESET : cb_pred;
    end else begin
      comp_sel = idq_pkg::COMP_CR;
      base_sel = skip ? idq_pkg::PRED_RESET : cr_pred;
    end
  end

  always_ff @(posedge clk) begin
    if (block_start) begin
      dc_base   <= base_sel;
      dc_comp   <= comp_sel;
      blk_scale <= quant_scale;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      luma_pred <= idq_pkg::PRED_RESET;
      cb_pred   <= idq_pkg::PRED_RESET;
      cr_pred   <= idq_pkg::PRED_RESET;
      last_addr <= idq_pkg::ADDR_RESET;
    end else begin
      if (cmd.accept && (kind == idq_pkg::KIND_SLICE)) begin
        luma_pred <= idq_pkg::PRED_RESET;
        cb_pred   <= idq_pkg::PRED_RESET;
        cr_pred   <= idq_pkg::PRED_RESET;
        last_addr <= idq_pkg::ADDR_RESET;
      end else if (block_start) begin
        if (skip && (block_number == 3'd0)) begin
          luma_pred <= idq_pkg::PRED_RESET;
          cb_pred   <= idq_pkg::PRED_RESET;
          cr_pred   <= idq_pkg::PRED_RESET;
        end
        last_addr <= $signed({2'd0, addr_sat});
      end else if (advance && c_valid && (c_k == 6'd0)) begin
        case (dc_comp)
          idq_pkg::COMP_LUMA: luma_pred <= dc_val;
          idq_pkg::COMP_CB:   cb_pred   <= dc_val;
          default:            cr_pred   <= dc_val;
        endcase
      end
    end
  end

  // stores
  always_ff @(posedge clk) begin
    if (coeff_accept) begin
      coeff_mem[position] <= level;
    end
    if (cmd.accept && (kind == idq_pkg::KIND_LOAD)) begin
      matrix_mem[position] <= matrix_value;
    end
    if (advance) begin
      a_level <= coeff_mem[idq_pkg::ZZ_OF_RASTER[cmd.index]];
      a_mval  <= matrix_mem[cmd.index];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coeff_written <= '0;
    end else begin
      if (cmd.clear_store) begin
        coeff_written <= '0;
      end
      if (coeff_accept) begin
        coeff_written[position] <= 1'b1;
      end
    end
  end

  // pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      c_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      a_valid   <= cmd.issue;
      b_valid   <= a_valid;
      c_valid   <= b_valid;
      out_valid <= c_valid;
    end
  end

  assign a_level_eff = a_written ? a_level : 9'sd0;
  // scale travels with each item so a new block can start while the old one drains
  assign scale_s     = $signed({1'b0, a_scale});

  always_ff @(posedge clk) begin
    if (advance) begin
      a_k       <= cmd.index;
      a_written <= coeff_written[idq_pkg::ZZ_OF_RASTER[cmd.index]];
      a_scale   <= blk_scale;
      b_k       <= a_k;
      b_level   <= a_level_eff;
      b_prod    <= 15'(a_level_eff) * 15'(scale_s);
      b_mval    <= a_mval;
      c_k       <= b_k;
      c_level   <= b_level;
      c_prod    <= 23'(b_prod) * $signed({15'd0, b_mval});
      out_k     <= c_k;
      out_value <= (c_k == 6'd0) ? dc_val : ac_val;
    end
  end

  // divide by 8 toward zero, pull even values toward zero, clamp
  always_comb begin
    quot = c_prod[22] ? ((c_prod + 23'sd7) >>> 3) : (c_prod >>> 3);
    odd_val = quot;
    if ((quot != 23'sd0) && !quot[0]) begin
      odd_val = quot[22] ? (quot + 23'sd1) : (quot - 23'sd1);
    end
    if (odd_val > 23'(idq_pkg::AC_MAX)) begin
      ac_val = idq_pkg::AC_MAX;
    end else if (odd_val < 23'(idq_pkg::AC_MIN)) begin
      ac_val = idq_pkg::AC_MIN;
    end else begin
      ac_val = odd_val[15:0];
    end
  end

  // dc: predictor plus eight times the differential, saturated
  always_comb begin
    dc_sum = 17'(dc_base) + $signed({{5{c_level[8]}}, c_level, 3'b000});
    if (dc_sum > 17'sd32767) begin
      dc_val = 16'sh7fff;
    end else if (dc_sum < -17'sd32768) begin
      dc_val = 16'sh8000;
    end else begin
      dc_val = dc_sum[15:0];
    end
  end

  assign recon_ch.valid       = out_valid;
  assign recon_ch.row         = out_k[5:3];
  assign recon_ch.column      = out_k[2:0];
  assign recon_ch.recon_value = out_value;
  assign recon_ch.last_out    = (out_k == idq_pkg::LAST_INDEX);

endmodule
`default_nettype wire

[src/intra_block_dequantizer.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// intra_block_dequantizer
// Inverse quantization of 8x8 intra blocks with DC prediction.
// ---------------------------------------------------------------------------
//  channel   role    carries
//  coeff_ch  sink    coefficient, matrix load and slice start items
//  recon_ch  source  64 raster-order recon items per block
//
//  Coefficient, load and slice items take one cycle each while idle.
//  The last coefficient starts a sweep of 64 reads from the coefficient and
//  matrix memories (one read port each); input is held off until the sweep ends.
//  Results leave a four-stage pipeline; a stall on recon_ch freezes all stages.
//  Reset clears the predictors, the skip address and the store valid bits.
// ---------------------------------------------------------------------------
module intra_block_dequantizer #(
  parameter int MB_ADDRESS_MAX = 8191
) (
  input wire logic    clk,
  input wire logic    rst,
  idq_coeff_if.sink   coeff_ch,
  idq_recon_if.source recon_ch
);

  idq_pkg::cmd_t    cmd;
  idq_pkg::status_t status;

  assign coeff_ch.ready = cmd.in_ready;

  idq_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (coeff_ch.valid),
    .in_kind       (coeff_ch.kind),
    .in_last_coeff (coeff_ch.last_coeff),
    .status        (status),
    .cmd           (cmd)
  );

  idq_datapath #(
    .MB_ADDRESS_MAX (MB_ADDRESS_MAX)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .kind         (coeff_ch.kind),
    .block_number (coeff_ch.block_number),
    .mb_address   (coeff_ch.mb_address),
    .quant_scale  (coeff_ch.quant_scale),
    .position     (coeff_ch.position),
    .level        (coeff_ch.level),
    .matrix_value (coeff_ch.matrix_value),
    .last_coeff   (coeff_ch.last_coeff),
    .status       (status),
    .recon_ch     (recon_ch)
  );

endmodule
`default_nettype wire

[test/tb.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the intra block dequantizer. A matrix load and a
// short directed run cover the field extremes, skip handling, odd block
// numbers and saturation; random macroblock streams with noise follow under
// several idle and stall mixes. Every recon item is checked in order against
// a behavioral dequantizer kept inside the bench.
// ---------------------------------------------------------------------------
module tb;

  localparam int MB_ADDRESS_MAX = 8191;
  localparam int LIMIT_CYCLES   = 1000000;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 16;
  localparam int DC_MAX         = 32767;
  localparam int DC_MIN         = -32768;

  localparam logic [1:0] KIND_NONE = 2'd3;
  localparam logic [2:0] BLOCK_Y0  = 3'd0;
  localparam logic signed [8:0] LEVEL_MAX = 9'sd255;
  localparam logic signed [8:0] LEVEL_MIN = -9'sd255 - 9'sd1;

  typedef struct {
    logic [1:0]        kind;
    logic [2:0]        block_number;
    logic [12:0]       mb_address;
    logic [4:0]        quant_scale;
    logic [5:0]        position;
    logic signed [8:0] level;
    logic [7:0]        matrix_value;
    logic              last_coeff;
  } coeff_item_t;

  typedef struct {
    logic [2:0]         row;
    logic [2:0]         column;
    logic signed [15:0] value;
    logic               last;
  } recon_t;

  logic clk;
  logic rst;

  idq_coeff_if coeff_ch ();
  idq_recon_if recon_ch ();

  intra_block_dequantizer #(
    .MB_ADDRESS_MAX(MB_ADDRESS_MAX)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .coeff_ch(coeff_ch),
    .recon_ch(recon_ch)
  );

  // dequantizer state
  logic signed [8:0] coeff_zz [64];
  logic [7:0]        qmatrix [64];
  int                pred_luma;
  int                pred_cb;
  int                pred_cr;
  int                prev_intra_addr;

  recon_t recon_expected [$];

  int  failures;
  int  items_sent;
  int  cycles;
  int  send_idle_pct;
  int  recv_stall_pct;
  int  hold_requests;
  int  hold_left;
  int  mb_addr;
  recon_t got;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic coeff_item_t make_item(input logic [1:0] kind, input logic [2:0] blk,
                                            input logic [12:0] addr, input logic [4:0] scale,
                                            input logic [5:0] pos, input logic signed [8:0] level,
                                            input logic [7:0] mval, input logic last);
    coeff_item_t it;
    it.kind         = kind;
    it.block_number = blk;
    it.mb_address   = addr;
    it.quant_scale  = scale;
    it.position     = pos;
    it.level        = level;
    it.matrix_value = mval;
    it.last_coeff   = last;
    return it;
  endfunction

  function automatic logic signed [8:0] rand_level();
    int t;
    t = int'($urandom_range(6)) - 3;
    case ($urandom_range(9))
      0: return LEVEL_MAX;
      1: return LEVEL_MIN;
      2, 3: return 9'(t);
      default: return 9'($urandom);
    endcase
  endfunction

  function automatic logic [4:0] rand_scale();
    if ($urandom_range(15) == 0) return 5'd0;
    return 5'($urandom_range(1, 31));
  endfunction

  task automatic reset_predictors();
    pred_luma = int'(idq_pkg::PRED_RESET);
    pred_cb   = int'(idq_pkg::PRED_RESET);
    pred_cr   = int'(idq_pkg::PRED_RESET);
  endtask

  // model one accepted item, queue the 64 recon items a block end causes
  task automatic dequantize_item(input coeff_item_t it);
    int     addr;
    int     pred;
    int     dc;
    int     v;
    bit     skip;
    recon_t r;
    case (it.kind)
      idq_pkg::KIND_LOAD: qmatrix[it.position] = it.matrix_value;
      idq_pkg::KIND_SLICE: begin
        reset_predictors();
        prev_intra_addr = int'(idq_pkg::ADDR_RESET);
      end
      idq_pkg::KIND_COEFF: begin
        coeff_zz[it.position] = it.level;
        if (it.last_coeff) begin
          addr = int'(it.mb_address);
          if (addr > MB_ADDRESS_MAX) addr = MB_ADDRESS_MAX;
          skip = (addr - prev_intra_addr) > 1;
          if (it.block_number == BLOCK_Y0 && skip) reset_predictors();
          if (it.block_number < idq_pkg::BLOCK_CB) pred = pred_luma;
          else if (skip) pred = int'(idq_pkg::PRED_RESET);
          else if (it.block_number == idq_pkg::BLOCK_CB) pred = pred_cb;
          else pred = pred_cr;
          dc = pred + 8 * int'(coeff_zz[0]);
          if (dc > DC_MAX) dc = DC_MAX;
          if (dc < DC_MIN) dc = DC_MIN;
          if (it.block_number < idq_pkg::BLOCK_CB) pred_luma = dc;
          else if (it.block_number == idq_pkg::BLOCK_CB) pred_cb = dc;
          else pred_cr = dc;
          prev_intra_addr = addr;
          for (int k = 0; k < 64; k++) begin
            if (k == 0) begin
              v = dc;
            end else begin
              v = (int'(coeff_zz[idq_pkg::ZZ_OF_RASTER[k]]) * int'(it.quant_scale) *
                   int'(qmatrix[k])) / 8;
              // even results step toward zero
              if (v[0] == 1'b0 && v != 0) v += (v > 0) ? -1 : 1;
              if (v > int'(idq_pkg::AC_MAX)) v = int'(idq_pkg::AC_MAX);
              if (v < int'(idq_pkg::AC_MIN)) v = int'(idq_pkg::AC_MIN);
            end
            r.row    = 3'(k >> 3);
            r.column = 3'(k & 7);
            r.value  = 16'(v);
            r.last   = (k == 63);
            recon_expected.push_back(r);
          end
          foreach (coeff_zz[i]) coeff_zz[i] = '0;
        end
      end
      default: ;
    endcase
  endtask

  task automatic send_item(input coeff_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      coeff_ch.valid = 1'b0;
    end
    @(negedge clk);
    coeff_ch.valid        = 1'b1;
    coeff_ch.kind         = it.kind;
    coeff_ch.block_number = it.block_number;
    coeff_ch.mb_address   = it.mb_address;
    coeff_ch.quant_scale  = it.quant_scale;
    coeff_ch.position     = it.position;
    coeff_ch.level        = it.level;
    coeff_ch.matrix_value = it.matrix_value;
    coeff_ch.last_coeff   = it.last_coeff;
    @(posedge clk);
    while (!coeff_ch.ready) @(posedge clk);
    dequantize_item(it);
    if (it.kind != KIND_NONE) items_sent++;
  endtask

  task automatic send_coeff(input logic [2:0] blk, input logic [12:0] addr,
                            input logic [4:0] scale, input logic [5:0] pos,
                            input logic signed [8:0] level, input logic last);
    send_item(make_item(idq_pkg::KIND_COEFF, blk, addr, scale, pos, level, 8'($urandom),
                        last));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    coeff_ch.valid = 1'b0;
    while (recon_expected.size() != 0) @(posedge clk);
  endtask

  // dc first (rarely a random position), up to four ac terms, last flag on the final one
  task automatic send_block(input logic [2:0] blk, input logic [12:0] addr);
    logic [4:0] scale;
    logic [5:0] pos;
    int         n;
    scale = rand_scale();
    n = $urandom_range(1, 5);
    for (int i = 0; i < n; i++) begin
      if (i == 0) pos = ($urandom_range(7) == 0) ? 6'($urandom_range(63)) : 6'd0;
      else pos = 6'($urandom_range(1, 63));
      send_coeff(blk, addr, scale, pos, rand_level(), i == n - 1);
    end
  endtask

  task automatic send_macroblock();
    int step;
    step = $urandom_range(99);
    if (step < 60) mb_addr = mb_addr + 1;
    else if (step < 70) mb_addr = mb_addr;
    else if (step < 85) mb_addr = mb_addr + $urandom_range(2, 5);
    else if (step < 92) mb_addr = $urandom_range(8100, MB_ADDRESS_MAX);
    else mb_addr = $urandom_range(0, MB_ADDRESS_MAX);
    if (mb_addr > MB_ADDRESS_MAX) mb_addr = $urandom_range(0, 15);
    for (int b = 0; b < 6; b++) begin
      if (b == 5 && $urandom_range(7) == 0) send_block(3'($urandom_range(6, 7)), 13'(mb_addr));
      else send_block(3'(b), 13'(mb_addr));
    end
  endtask

  task automatic send_noise();
    case ($urandom_range(4))
      0: send_item(make_item(KIND_NONE, 3'($urandom), 13'($urandom), 5'($urandom),
                             6'($urandom), 9'($urandom), 8'($urandom), 1'($urandom)));
      1: send_item(make_item(idq_pkg::KIND_SLICE, 3'($urandom), 13'($urandom), 5'($urandom),
                             6'($urandom), 9'($urandom), 8'($urandom), 1'($urandom)));
      2: send_item(make_item(idq_pkg::KIND_LOAD, 3'($urandom), 13'($urandom), 5'($urandom),
                             6'($urandom), 9'($urandom), 8'($urandom_range(1, 255)),
                             1'($urandom)));
      3: send_coeff(3'($urandom), 13'(mb_addr), rand_scale(), 6'($urandom), rand_level(),
                    1'($urandom));
      default: send_block(3'($urandom), 13'(mb_addr));
    endcase
  endtask

  task automatic test_matrix_load();
    logic [7:0] mval;
    for (int k = 0; k < 64; k++) begin
      if (k == 0) mval = 8'd1;
      else if (k == 1 || k == 63) mval = 8'd255;
      else mval = 8'($urandom_range(1, 255));
      send_item(make_item(idq_pkg::KIND_LOAD, 3'd0, 13'd0, 5'd1, 6'(k), 9'sd0, mval, 1'b0));
    end
  endtask

  task automatic test_directed();
    send_item(make_item(KIND_NONE, 3'd7, 13'h1fff, 5'd31, 6'd63, LEVEL_MIN, 8'd255, 1'b1));
    send_item(make_item(idq_pkg::KIND_SLICE, 3'd0, 13'd0, 5'd1, 6'd0, 9'sd0, 8'd1, 1'b0));
    // clamps at both ends of the ac range
    send_coeff(3'd0, 13'd0, 5'd31, 6'd63, LEVEL_MAX, 1'b0);
    send_coeff(3'd0, 13'd0, 5'd31, 6'd1, LEVEL_MIN, 1'b0);
    send_coeff(3'd0, 13'd0, 5'd31, 6'd0, LEVEL_MAX, 1'b1);
    send_coeff(3'd1, 13'd0, 5'd1, 6'd5, 9'sd1, 1'b0);
    send_coeff(3'd1, 13'd0, 5'd1, 6'd0, LEVEL_MIN, 1'b1);
    // zero scale
    send_coeff(3'd4, 13'd0, 5'd0, 6'd10, 9'sd100, 1'b0);
    send_coeff(3'd4, 13'd0, 5'd0, 6'd0, 9'sd7, 1'b1);
    send_coeff(3'd5, 13'd0, 5'd2, 6'd0, -9'sd1, 1'b1);
    // block numbers past cr, block ending on an ac term
    send_coeff(3'd7, 13'd1, 5'd3, 6'd2, 9'sd3, 1'b1);
    send_coeff(3'd6, 13'd1, 5'd5, 6'd0, 9'sd4, 1'b1);
    // skip at block zero with the top address
    send_coeff(3'd0, 13'h1fff, 5'd16, 6'd0, 9'sd0, 1'b1);
    send_coeff(3'd4, 13'h1fff, 5'd16, 6'd0, LEVEL_MAX, 1'b1);
    // skip seen first at a chroma block
    send_item(make_item(idq_pkg::KIND_SLICE, 3'd5, 13'd5, 5'd9, 6'd9, 9'sd9, 8'd9, 1'b1));
    send_coeff(3'd4, 13'd100, 5'd8, 6'd3, 9'sd50, 1'b0);
    send_coeff(3'd4, 13'd100, 5'd8, 6'd0, -9'sd10, 1'b1);
    send_coeff(3'd5, 13'd100, 5'd8, 6'd0, 9'sd20, 1'b1);
    // skip at a later luma block keeps the predictor
    send_coeff(3'd2, 13'd103, 5'd4, 6'd0, 9'sd1, 1'b1);
    send_item(make_item(idq_pkg::KIND_LOAD, 3'd0, 13'd0, 5'd1, 6'd9, 9'sd0, 8'd2, 1'b0));
    send_coeff(3'd3, 13'd103, 5'd31, 6'd4, LEVEL_MIN, 1'b0);
    send_coeff(3'd3, 13'd103, 5'd31, 6'd0, -9'sd5, 1'b1);
    wait_drained();
  endtask

  // drive the luma predictor into both saturation limits
  task automatic test_dc_saturation();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (17) send_coeff(3'($urandom_range(1, 3)), 13'(prev_intra_addr), rand_scale(), 6'd0,
                           9'($urandom_range(240, 255)), 1'b1);
    repeat (36) send_coeff(3'($urandom_range(1, 3)), 13'(prev_intra_addr), rand_scale(), 6'd0,
                           9'(-int'($urandom_range(240, 256))), 1'b1);
    wait_drained();
  endtask

  task automatic test_random_phase(input int items, input int idle, input int stall);
    int goal;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    goal = items_sent + items;
    while (items_sent < goal) begin
      if ($urandom_range(99) < 80) send_macroblock();
      else send_noise();
    end
    wait_drained();
  endtask

  // long receiver hold while the sender keeps offering items
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_requests++;
    send_macroblock();
    send_macroblock();
    wait_drained();
    recv_stall_pct = 30;
    send_macroblock();
    wait_drained();
  endtask

  // receiver
  initial begin
    int hold_served;
    hold_served    = 0;
    hold_left      = 0;
    recon_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requests != hold_served) begin
        hold_left = HOLD_CYCLES;
        hold_served = hold_requests;
      end
      if (hold_left > 0) begin
        hold_left--;
        recon_ch.ready = 1'b0;
      end else begin
        recon_ch.ready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && recon_ch.valid && recon_ch.ready) begin
      if (recon_expected.size() == 0) begin
        failures++;
        $display("%0t unexpected item: row %0d col %0d value %0d last %0d", $time,
                 recon_ch.row, recon_ch.column, recon_ch.recon_value, recon_ch.last_out);
      end else begin
        got = recon_expected.pop_front();
        if (recon_ch.row !== got.row || recon_ch.column !== got.column ||
            recon_ch.recon_value !== got.value || recon_ch.last_out !== got.last) begin
          failures++;
          $display("%0t mismatch: expected (%0d,%0d) %0d last %0d, got (%0d,%0d) %0d last %0d",
                   $time, got.row, got.column, got.value, got.last, recon_ch.row,
                   recon_ch.column, recon_ch.recon_value, recon_ch.last_out);
        end
      end
    end
  end

  initial begin
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL intra_block_dequantizer");
    $finish;
  end

  initial begin
    rst = 1'b1;
    coeff_ch.valid        = 1'b0;
    coeff_ch.kind         = idq_pkg::KIND_COEFF;
    coeff_ch.block_number = '0;
    coeff_ch.mb_address   = '0;
    coeff_ch.quant_scale  = '0;
    coeff_ch.position     = '0;
    coeff_ch.level        = '0;
    coeff_ch.matrix_value = '0;
    coeff_ch.last_coeff   = 1'b0;
    items_sent     = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_requests  = 0;
    mb_addr        = 0;
    foreach (coeff_zz[i]) coeff_zz[i] = '0;
    reset_predictors();
    prev_intra_addr = int'(idq_pkg::ADDR_RESET);
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_matrix_load();
    test_directed();
    test_dc_saturation();
    test_random_phase(20, 0, 0);
    test_random_phase(20, 83, 0);
    test_random_phase(20, 0, 83);
    test_random_phase(20, 18, 18);
    test_backpressure();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0 && recon_expected.size() == 0) begin
      $display("PASS intra_block_dequantizer");
    end else begin
      $display("FAIL intra_block_dequantizer");
    end
    $finish;
  end

endmodule
